// File: hw/rtl/bps_pkg.sv
`default_nettype none

package bps_pkg;

    localparam int TICK_W = 16;
    localparam int REG_INDEX_W = 3;

    typedef enum logic [2:0] {
        SYM_END           = 3'd0,
        SYM_DASH          = 3'd1,
        SYM_DOT           = 3'd2,
        SYM_FLICKER       = 3'd3,
        SYM_FLICKER_SHORT = 3'd4,
        SYM_PAUSE         = 3'd5,
        SYM_REPEAT        = 3'd6,
        SYM_OTHER         = 3'd7
    } symbol_t;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_PATTERN   = 3'd0,
        REG_DASH      = 3'd1,
        REG_DOT       = 3'd2,
        REG_FLICKER   = 3'd3,
        REG_GAP       = 3'd4,
        REG_SHORT_GAP = 3'd5,
        REG_CHAR_GAP  = 3'd6,
        REG_SYNC_MODE = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [TICK_W-1:0] dash;
        logic [TICK_W-1:0] dot;
        logic [TICK_W-1:0] flicker;
        logic [TICK_W-1:0] gap;
        logic [TICK_W-1:0] short_gap;
        logic [TICK_W-1:0] char_gap;
        logic              sync_mode;
    } timing_t;

    typedef struct packed {
        logic period_done;
        logic tone;
        logic enable;
        logic gap_pending;
        logic short_gap_select;
        logic char_gap_pending;
        logic repeat_pending;
        logic sync;
        logic active;
    } flags_t;

    localparam flags_t FLAGS_RESET = '{
        period_done:      1'b1,
        tone:             1'b0,
        enable:           1'b0,
        gap_pending:      1'b0,
        short_gap_select: 1'b0,
        char_gap_pending: 1'b0,
        repeat_pending:   1'b0,
        sync:             1'b0,
        active:           1'b0
    };

endpackage

`default_nettype wire

// File: hw/rtl/bps_step.sv
`default_nettype none

module bps_step
    import bps_pkg::*;
#(
    parameter int PATTERN_LENGTH = 14,
    parameter int COUNT_WIDTH = 16,
    parameter int PTR_W = $clog2(PATTERN_LENGTH + 1)
) (
    input  wire logic                        op,
    input  wire logic                        inhibit,
    input  wire logic                        second_mark,
    input  wire logic [3*PATTERN_LENGTH-1:0] pattern,
    input  wire timing_t                     timing,
    input  wire flags_t                      flags,
    input  wire logic [COUNT_WIDTH-1:0]      count,
    input  wire logic [COUNT_WIDTH-1:0]      limit,
    input  wire logic [PTR_W-1:0]            pointer,
    output flags_t                           flags_next,
    output logic [COUNT_WIDTH-1:0]           count_next,
    output logic [COUNT_WIDTH-1:0]           limit_next,
    output logic [PTR_W-1:0]                 pointer_next
);

    symbol_t codes [PATTERN_LENGTH:0];

    genvar k;
    generate
        for (k = 0; k < PATTERN_LENGTH; k++)
        begin : g_codes
            assign codes[k] = symbol_t'(pattern[3*k +: 3]);
        end
    endgenerate
    assign codes[PATTERN_LENGTH] = SYM_END;

    always_comb
    begin
        logic [TICK_W-1:0]             len;
        logic [COUNT_WIDTH+TICK_W-1:0] len_ext;
        logic [COUNT_WIDTH-1:0]        count_inc;
        logic                          start;
        logic                          start_tone;
        symbol_t                       code;

        flags_next   = flags;
        count_next   = count;
        limit_next   = limit;
        pointer_next = pointer;
        len          = timing.gap;
        start        = 1'b0;
        start_tone   = 1'b0;
        count_inc    = count + COUNT_WIDTH'(1);
        code         = codes[pointer];

        if (second_mark)
        begin
            flags_next.sync = 1'b1;
        end

        if (op)
        begin
            pointer_next                = '0;
            flags_next.enable           = 1'b0;
            flags_next.period_done      = 1'b1;
            flags_next.repeat_pending   = 1'b0;
            flags_next.char_gap_pending = 1'b0;
            flags_next.gap_pending      = 1'b0;
            flags_next.sync             = 1'b0;
        end
        else if (!inhibit)
        begin
            if (!flags.period_done)
            begin
                if (count != '0)
                begin
                    count_next = count_inc;
                    if (count_inc >= limit)
                    begin
                        count_next             = '0;
                        flags_next.tone        = 1'b0;
                        flags_next.period_done = 1'b1;
                    end
                end
            end
            else if (flags.char_gap_pending)
            begin
                flags_next.char_gap_pending = 1'b0;
                start = 1'b1;
                len   = timing.sync_mode ? timing.char_gap : timing.gap;
            end
            else if (flags.gap_pending)
            begin
                flags_next.gap_pending = 1'b0;
                start = 1'b1;
                len   = flags.short_gap_select ? timing.short_gap : timing.gap;
            end
            else if (flags.repeat_pending)
            begin
                flags_next.repeat_pending = 1'b0;
                pointer_next = '0;
            end
            else if (code != SYM_END && !(timing.sync_mode && !flags_next.sync))
            begin
                case (code)
                    SYM_DASH:
                    begin
                        start      = 1'b1;
                        start_tone = 1'b1;
                        len        = timing.dash;
                        flags_next.gap_pending      = 1'b1;
                        flags_next.short_gap_select = 1'b0;
                    end
                    SYM_DOT:
                    begin
                        start      = 1'b1;
                        start_tone = 1'b1;
                        len        = timing.dot;
                        flags_next.gap_pending      = 1'b1;
                        flags_next.short_gap_select = 1'b0;
                    end
                    SYM_FLICKER:
                    begin
                        start      = 1'b1;
                        start_tone = 1'b1;
                        len        = timing.flicker;
                        flags_next.gap_pending      = 1'b1;
                        flags_next.short_gap_select = 1'b0;
                    end
                    SYM_FLICKER_SHORT:
                    begin
                        start      = 1'b1;
                        start_tone = 1'b1;
                        len        = timing.flicker;
                        flags_next.gap_pending      = 1'b1;
                        flags_next.short_gap_select = 1'b1;
                    end
                    SYM_PAUSE:
                    begin
                        flags_next.short_gap_select = 1'b0;
                        flags_next.char_gap_pending = 1'b1;
                        flags_next.period_done      = 1'b1;
                        flags_next.sync             = 1'b0;
                        flags_next.active           = 1'b0;
                    end
                    SYM_REPEAT:
                    begin
                        flags_next.repeat_pending = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                if (code != SYM_PAUSE && code != SYM_REPEAT)
                begin
                    flags_next.active = 1'b1;
                end
                if (code != SYM_REPEAT)
                begin
                    pointer_next = pointer + PTR_W'(1);
                end
            end
        end

        len_ext = {{COUNT_WIDTH{1'b0}}, len};
        if (start)
        begin
            limit_next             = len_ext[COUNT_WIDTH-1:0];
            count_next             = COUNT_WIDTH'(1);
            flags_next.period_done = 1'b0;
            flags_next.tone        = start_tone;
            flags_next.enable      = start_tone;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/beep_pattern_sequencer_top.sv
`default_nettype none

// Beep pattern sequencer. Each input beat is one tick (tuser low) or a restart
// (tuser high); it steps the pattern held in the pattern register and yields one
// output beat with the tone, sounder enable and pattern activity flags after the
// step. One beat is taken every clock cycle while the output is not stalled; a
// result passes through the input register and then the result register, with
// the combinational step logic between them. A stall on the output holds the input
// register, and the input side keeps taking beats while it has room.

module beep_pattern_sequencer_top
    import bps_pkg::*;
#(
    parameter int PATTERN_LENGTH = 14,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wen,
    input  wire logic [REG_INDEX_W-1:0]        cfg_index,
    input  wire logic [((3*PATTERN_LENGTH > TICK_W) ? 3*PATTERN_LENGTH : TICK_W)-1:0]
                                               cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // inhibit, second_mark, zero pad
    input  wire logic                          s_tuser,   // op
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata    // tone_on, drive_enable,
                                                          // pattern_active, zero pad
);

    localparam int PTR_W = $clog2(PATTERN_LENGTH + 1);

    logic [3*PATTERN_LENGTH-1:0] pattern_reg;
    timing_t                     timing_reg;

    flags_t                      flags_reg, flags_next;
    logic [COUNT_WIDTH-1:0]      count_reg, count_next;
    logic [COUNT_WIDTH-1:0]      limit_reg, limit_next;
    logic [PTR_W-1:0]            pointer_reg, pointer_next;

    logic                        in_valid_reg;
    logic                        in_op_reg;
    logic                        in_inhibit_reg;
    logic                        in_mark_reg;
    logic                        out_valid_reg;
    logic [2:0]                  out_data_reg;
    logic                        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg          <= '0;
            timing_reg.dash      <= TICK_W'(30);
            timing_reg.dot       <= TICK_W'(10);
            timing_reg.flicker   <= TICK_W'(3);
            timing_reg.gap       <= TICK_W'(10);
            timing_reg.short_gap <= TICK_W'(5);
            timing_reg.char_gap  <= TICK_W'(50);
            timing_reg.sync_mode <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (reg_index_t'(cfg_index))
                REG_PATTERN:   pattern_reg          <= cfg_wdata[3*PATTERN_LENGTH-1:0];
                REG_DASH:      timing_reg.dash      <= cfg_wdata[TICK_W-1:0];
                REG_DOT:       timing_reg.dot       <= cfg_wdata[TICK_W-1:0];
                REG_FLICKER:   timing_reg.flicker   <= cfg_wdata[TICK_W-1:0];
                REG_GAP:       timing_reg.gap       <= cfg_wdata[TICK_W-1:0];
                REG_SHORT_GAP: timing_reg.short_gap <= cfg_wdata[TICK_W-1:0];
                REG_CHAR_GAP:  timing_reg.char_gap  <= cfg_wdata[TICK_W-1:0];
                REG_SYNC_MODE: timing_reg.sync_mode <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg      <= s_tuser;
            in_inhibit_reg <= s_tdata[0];
            in_mark_reg    <= s_tdata[1];
        end
    end

    bps_step #(
        .PATTERN_LENGTH (PATTERN_LENGTH),
        .COUNT_WIDTH    (COUNT_WIDTH),
        .PTR_W          (PTR_W)
    ) u_step (
        .op           (in_op_reg),
        .inhibit      (in_inhibit_reg),
        .second_mark  (in_mark_reg),
        .pattern      (pattern_reg),
        .timing       (timing_reg),
        .flags        (flags_reg),
        .count        (count_reg),
        .limit        (limit_reg),
        .pointer      (pointer_reg),
        .flags_next   (flags_next),
        .count_next   (count_next),
        .limit_next   (limit_next),
        .pointer_next (pointer_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= FLAGS_RESET;
            count_reg     <= '0;
            limit_reg     <= '0;
            pointer_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                flags_reg   <= flags_next;
                count_reg   <= count_next;
                limit_reg   <= limit_next;
                pointer_reg <= pointer_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result beat: tone, enable, active after the step
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {flags_next.active, flags_next.enable, flags_next.tone};
        end
    end

endmodule

`default_nettype wire
